### sv/cos_pkg.sv
package cos_pkg;

  localparam int MAX_GROUPS    = 256;
  localparam int MAX_PER_GROUP = 64;
  localparam int NUM_OPERATORS = 256;
  localparam int FRAC_BITS     = 16;

  localparam int GIDX_W  = $clog2(MAX_GROUPS);
  localparam int GCNT_W  = $clog2(MAX_GROUPS + 1);
  localparam int MIDX_W  = $clog2(MAX_PER_GROUP);
  localparam int MCNT_W  = 7;
  localparam int OPID_W  = 8;
  localparam int MADDR_W = GIDX_W + MIDX_W;

  localparam int DIVW    = 32 + FRAC_BITS;
  localparam int PENW    = 16 + 9;
  localparam int SCOREW  = 58;
  localparam int STEP_W  = $clog2(DIVW + 1);

  localparam logic [SCOREW-1:0] UNPROFILED_SCORE = SCOREW'(1000) << FRAC_BITS;
  localparam logic [8:0]        FAILURE_COST     = 9'd500;

  typedef enum logic [1:0] {
    ACT_REGISTER = 2'd0,
    ACT_PROFILE  = 2'd1,
    ACT_CHOOSE   = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_GROUP_FULL = 2'd1,
    ST_TABLE_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic [31:0] calls;
    logic [31:0] cycles;
    logic [15:0] fails;
  } profile_t;

endpackage

### sv/capability_operator_selector.sv
// Capability operator selector.
// Input channel (in_valid/in_ready) takes one word per item: action, capability,
// operator_id and the profile values. Result channel (out_valid/out_ready) gives
// one word per item: status, found, chosen_operator. cfg_valid/cfg_data writes
// policy_enabled; cfg_ready is always high.
// One item is in work at a time. A profile write, an unknown action and a choose
// while the policy is off go straight to the result. Register and choose scan the
// group key memory, one key read and one compare per group visited. Choose then
// walks the group's members: one member read, one profile read, an operand latch,
// a 48-step restoring divider that forms the average cycle count (skipped for an
// unprofiled member or one with zero calls), and a compare.
// Reset clears the group count, the profile valid bits and the policy; profile
// entries never written score as unprofiled. No clearing pass is needed.
// The finished result sits in an output register; a new word is accepted
// while it waits. If the receiver stalls, the next result holds in the block
// until the output register frees.
module capability_operator_selector
  import cos_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_capability,
  input  logic [7:0]  in_operator_id,
  input  logic [31:0] in_call_count,
  input  logic [31:0] in_cycle_total,
  input  logic [15:0] in_failure_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_found,
  output logic [7:0]  out_chosen_operator,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_KRD, S_KCMP, S_MISS, S_MRD, S_PRD, S_PLD, S_DIV, S_CMP, S_DONE
  } state_t;

  state_t state_r;

  // memories
  logic [31:0]        key_mem  [MAX_GROUPS];
  logic [MCNT_W-1:0]  size_mem [MAX_GROUPS];
  logic [OPID_W-1:0]  memb_mem [MAX_GROUPS*MAX_PER_GROUP];
  profile_t           prof_mem [NUM_OPERATORS];
  logic [NUM_OPERATORS-1:0] prof_vld_r;

  logic [31:0]       key_q;
  logic [MCNT_W-1:0] size_q;
  logic [OPID_W-1:0] memb_q;
  profile_t          prof_q;
  logic              prof_vld_q;

  // control and payload registers
  logic              policy_r;
  logic [GCNT_W-1:0] giu_r;
  logic [GIDX_W-1:0] idx_r;
  logic [GIDX_W-1:0] grp_r;
  logic [MIDX_W-1:0] j_r;
  logic [MCNT_W-1:0] n_r;
  logic [1:0]        act_r;
  logic [31:0]       cap_r;
  logic [OPID_W-1:0] id_r;
  logic [32:0]       rem_r;
  logic [DIVW-1:0]   dq_r;
  logic [31:0]       dvs_r;
  logic [STEP_W-1:0] step_r;
  logic [SCOREW-1:0] pen_r;
  logic [SCOREW-1:0] best_r;
  logic [OPID_W-1:0] cand_r;
  logic [OPID_W-1:0] chosen_r;
  logic [1:0]        res_status_r;
  logic              res_found_r;
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic              out_found_r;
  logic [7:0]        out_chosen_r;

  // memory write controls
  logic              key_we, size_we, memb_we;
  logic [GIDX_W-1:0] gw_addr;
  logic [MCNT_W-1:0] size_wd;
  logic [MADDR_W-1:0] memb_waddr;
  logic              in_acc;
  logic              key_hit;
  logic              last_grp;
  logic [32:0]       div_tmp;
  logic              div_bit;
  logic [SCOREW-1:0] score;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign key_hit   = (key_q == cap_r);
  assign last_grp  = ((GCNT_W'(idx_r) + GCNT_W'(1)) == giu_r);
  assign div_tmp   = {rem_r[31:0], dq_r[DIVW-1]};
  assign div_bit   = (div_tmp >= {1'b0, dvs_r});
  assign score     = SCOREW'(dq_r) + pen_r;

  // group table writes: append on hit, open on miss
  always_comb begin
    key_we     = 1'b0;
    size_we    = 1'b0;
    memb_we    = 1'b0;
    gw_addr    = idx_r;
    size_wd    = size_q + MCNT_W'(1);
    memb_waddr = {idx_r, size_q[MIDX_W-1:0]};
    if (state_r == S_KCMP && act_r == ACT_REGISTER && key_hit &&
        size_q < MCNT_W'(MAX_PER_GROUP)) begin
      size_we = 1'b1;
      memb_we = 1'b1;
    end else if (state_r == S_MISS && act_r == ACT_REGISTER &&
                 giu_r < GCNT_W'(MAX_GROUPS)) begin
      key_we     = 1'b1;
      size_we    = 1'b1;
      memb_we    = 1'b1;
      gw_addr    = giu_r[GIDX_W-1:0];
      size_wd    = MCNT_W'(1);
      memb_waddr = {giu_r[GIDX_W-1:0], MIDX_W'(0)};
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (key_we) key_mem[gw_addr] <= cap_r;
    if (size_we) size_mem[gw_addr] <= size_wd;
    if (memb_we) memb_mem[memb_waddr] <= id_r;
    if (in_acc && in_action == ACT_PROFILE)
      prof_mem[in_operator_id] <= '{calls: in_call_count, cycles: in_cycle_total,
                                    fails: in_failure_count};
    key_q      <= key_mem[idx_r];
    size_q     <= size_mem[idx_r];
    memb_q     <= memb_mem[{grp_r, j_r}];
    prof_q     <= prof_mem[memb_q];
    prof_vld_q <= prof_vld_r[memb_q];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      policy_r    <= 1'b0;
      giu_r       <= '0;
      prof_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) policy_r <= cfg_data;
      if (out_valid_r && out_ready && state_r != S_DONE) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            act_r        <= in_action;
            cap_r        <= in_capability;
            id_r         <= in_operator_id;
            idx_r        <= '0;
            res_status_r <= ST_OK;
            res_found_r  <= 1'b0;
            chosen_r     <= '0;
            if (in_action == ACT_PROFILE) begin
              prof_vld_r[in_operator_id] <= 1'b1;
              state_r <= S_DONE;
            end else if (in_action == ACT_REGISTER ||
                         (in_action == ACT_CHOOSE && policy_r)) begin
              state_r <= (giu_r == '0) ? S_MISS : S_KRD;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_KRD: state_r <= S_KCMP;
        S_KCMP: begin
          if (key_hit) begin
            if (act_r == ACT_REGISTER) begin
              if (size_q >= MCNT_W'(MAX_PER_GROUP)) res_status_r <= ST_GROUP_FULL;
              state_r <= S_DONE;
            end else if (size_q == '0) begin
              state_r <= S_DONE;
            end else begin
              grp_r   <= idx_r;
              n_r     <= size_q;
              j_r     <= '0;
              state_r <= S_MRD;
            end
          end else if (last_grp) begin
            state_r <= S_MISS;
          end else begin
            idx_r   <= idx_r + GIDX_W'(1);
            state_r <= S_KRD;
          end
        end
        S_MISS: begin
          if (act_r == ACT_REGISTER) begin
            if (giu_r < GCNT_W'(MAX_GROUPS)) giu_r <= giu_r + GCNT_W'(1);
            else res_status_r <= ST_TABLE_FULL;
          end
          state_r <= S_DONE;
        end
        S_MRD: state_r <= S_PRD;
        S_PRD: state_r <= S_PLD;
        S_PLD: begin
          // latch operands; an unwritten profile gets no penalty and the unprofiled score
          cand_r <= memb_q;
          pen_r  <= prof_vld_q ?
                    (SCOREW'(PENW'(prof_q.fails) * PENW'(FAILURE_COST)) << FRAC_BITS)
                    : '0;
          rem_r  <= '0;
          dvs_r  <= prof_q.calls;
          step_r <= '0;
          if (!prof_vld_q || prof_q.calls == '0) begin
            dq_r    <= DIVW'(UNPROFILED_SCORE);
            state_r <= S_CMP;
          end else begin
            dq_r    <= {prof_q.cycles, FRAC_BITS'(0)};
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          // one quotient bit per cycle
          rem_r  <= div_bit ? (div_tmp - {1'b0, dvs_r}) : div_tmp;
          dq_r   <= {dq_r[DIVW-2:0], div_bit};
          step_r <= step_r + STEP_W'(1);
          if (step_r == STEP_W'(DIVW - 1)) state_r <= S_CMP;
        end
        S_CMP: begin
          if (j_r == '0 || score < best_r) begin
            best_r   <= score;
            chosen_r <= cand_r;
          end
          if ((MCNT_W'(j_r) + MCNT_W'(1)) == n_r) begin
            res_found_r <= 1'b1;
            state_r     <= S_DONE;
          end else begin
            j_r     <= j_r + MIDX_W'(1);
            state_r <= S_MRD;
          end
        end
        S_DONE: begin
          // hold until the output register frees
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_found_r  <= res_found_r;
            out_chosen_r <= res_found_r ? chosen_r : '0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_found           = out_found_r;
  assign out_chosen_operator = out_chosen_r;

`ifndef NO_ASSERTIONS
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == ST_OK)
    else $error("found result with nonzero status");
  a_giu_bound: assert property (@(posedge clk) disable iff (!rst_n)
    giu_r <= GCNT_W'(MAX_GROUPS))
    else $error("group count beyond table");
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while busy");
`endif

endmodule

### test/tb_capability_operator_selector.sv
module tb_capability_operator_selector;
  import cos_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 200000;
  localparam int N_RANDOM    = 1200;
  localparam int TAIL_ITEMS  = 150;

  // Key pool for registrations; one key (key_pool[2]) gets filled to capacity.
  localparam int N_KEYS = 12;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [7:0] chosen;
  } result_t;

  // Scoreboard: mirrors the group table and profile store, queues results.
  class selector_scoreboard;
    logic [31:0] keys [MAX_GROUPS];
    int          sizes [MAX_GROUPS];
    logic [7:0]  members [MAX_GROUPS][MAX_PER_GROUP];
    int          n_groups;
    logic [31:0] p_calls [NUM_OPERATORS];
    logic [31:0] p_cycles [NUM_OPERATORS];
    logic [15:0] p_fails [NUM_OPERATORS];
    bit          policy_on;
    result_t     pending [$];
    int          errors;

    function void clear();
      n_groups = 0;
      policy_on = 0;
      errors = 0;
      foreach (p_calls[i]) begin
        p_calls[i] = '0;
        p_cycles[i] = '0;
        p_fails[i] = '0;
      end
    endfunction

    function logic [63:0] score(logic [7:0] id);
      logic [63:0] avg;
      if (p_calls[id] != 0) avg = ({32'd0, p_cycles[id]} << FRAC_BITS) / p_calls[id];
      else avg = 64'd1000 << FRAC_BITS;
      return avg + (({48'd0, p_fails[id]} * 64'd500) << FRAC_BITS);
    endfunction

    function int find_group(logic [31:0] key);
      for (int g = 0; g < n_groups; g++)
        if (keys[g] == key) return g;
      return -1;
    endfunction

    // Note an accepted input word and queue its expected result.
    function void note_input(logic [1:0] act, logic [31:0] cap, logic [7:0] id,
                             logic [31:0] calls, logic [31:0] cyc, logic [15:0] fails);
      result_t r;
      int g;
      logic [63:0] best, s;
      r = '0;
      case (act)
        ACT_REGISTER: begin
          g = find_group(cap);
          if (g >= 0) begin
            if (sizes[g] >= MAX_PER_GROUP) r.status = ST_GROUP_FULL;
            else begin
              members[g][sizes[g]] = id;
              sizes[g]++;
            end
          end else if (n_groups >= MAX_GROUPS) r.status = ST_TABLE_FULL;
          else begin
            keys[n_groups] = cap;
            members[n_groups][0] = id;
            sizes[n_groups] = 1;
            n_groups++;
          end
        end
        ACT_PROFILE: begin
          p_calls[id] = calls;
          p_cycles[id] = cyc;
          p_fails[id] = fails;
        end
        ACT_CHOOSE: begin
          g = find_group(cap);
          if (policy_on && g >= 0 && sizes[g] > 0) begin
            r.found = 1'b1;
            r.chosen = members[g][0];
            best = score(r.chosen);
            for (int j = 1; j < sizes[g]; j++) begin
              s = score(members[g][j]);
              if (s < best) begin
                best = s;
                r.chosen = members[g][j];
              end
            end
          end
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void report(string what, logic [7:0] got, logic [7:0] want);
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
      errors++;
    endfunction

    // Compare one accepted result word with the oldest expectation.
    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $display("mismatch: result word with nothing expected");
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) report("status", got.status, want.status);
      if (got.found !== want.found) report("found", got.found, want.found);
      if (got.chosen !== want.chosen) report("chosen_operator", got.chosen, want.chosen);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_action;
  logic [31:0] in_capability;
  logic [7:0]  in_operator_id;
  logic [31:0] in_call_count;
  logic [31:0] in_cycle_total;
  logic [15:0] in_failure_count;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic        out_found;
  logic [7:0]  out_chosen_operator;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;

  selector_scoreboard sb;
  logic [31:0] key_pool [N_KEYS];
  bit          quiet_phase;
  bit          long_hold;
  int          idle_cycles;

  capability_operator_selector u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_capability       (in_capability),
    .in_operator_id      (in_operator_id),
    .in_call_count       (in_call_count),
    .in_cycle_total      (in_cycle_total),
    .in_failure_count    (in_failure_count),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_found           (out_found),
    .out_chosen_operator (out_chosen_operator),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Send one word; leave valid high when the next word follows at once.
  task automatic send_word(logic [1:0] act, logic [31:0] cap, logic [7:0] id,
                           logic [31:0] calls, logic [31:0] cyc, logic [15:0] fails);
    int gap;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 13);
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_action        <= act;
    in_capability    <= cap;
    in_operator_id   <= id;
    in_call_count    <= calls;
    in_cycle_total   <= cyc;
    in_failure_count <= fails;
    do @(posedge clk); while (!in_ready);
    sb.note_input(act, cap, id, calls, cyc, fails);
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
  endtask

  // Wait until every result is back, then write the policy register.
  task automatic write_policy(bit value);
    drop_valid();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.policy_on = value;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return key_pool[$urandom_range(0, N_KEYS - 1)];
  endfunction

  // One random word, mostly register/profile/choose on pooled keys.
  task automatic send_random();
    int sel;
    logic [31:0] calls;
    sel = $urandom_range(0, 99);
    calls = ($urandom_range(0, 4) == 0) ? 32'd0 :
            ($urandom_range(0, 1) ? $urandom() : $urandom_range(1, 50));
    if (sel < 35)
      send_word(ACT_REGISTER, pick_key(), 8'($urandom()), $urandom(), $urandom(),
                16'($urandom()));
    else if (sel < 65)
      send_word(ACT_PROFILE, $urandom(), 8'($urandom()), calls,
                $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 60000),
                16'($urandom_range(0, 2) == 0 ? $urandom() : $urandom_range(0, 3)));
    else if (sel < 97)
      send_word(ACT_CHOOSE, pick_key(), 8'($urandom()), $urandom(), $urandom(),
                16'($urandom()));
    else
      send_word(ACT_NONE, $urandom(), 8'($urandom()), $urandom(), $urandom(),
                16'($urandom()));
  endtask

  // Result side: random stalls, one long hold-off, none in the last part.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        sb.check_result('{out_status, out_found, out_chosen_operator});
      if (long_hold) begin
        out_ready <= 1'b0;
      end else if (idle_cycles > 0) begin
        idle_cycles <= idle_cycles - 1;
        out_ready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        idle_cycles <= $urandom_range(1, 13) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  int stuck;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || long_hold) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
      if (stuck >= STALL_LIMIT) begin
        $display("tb_capability_operator_selector: done, errors");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    sb.clear();
    quiet_phase = 0;
    long_hold = 0;
    idle_cycles = 0;
    stuck = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_action <= '0;
    in_capability <= '0;
    in_operator_id <= '0;
    in_call_count <= '0;
    in_cycle_total <= '0;
    in_failure_count <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= 1'b0;
    foreach (key_pool[i]) key_pool[i] = $urandom();
    key_pool[0] = 32'd0;
    key_pool[1] = 32'hFFFF_FFFF;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: choose with policy off, extremes, unknown action.
    send_word(ACT_REGISTER, 32'd0, 8'd0, '0, '0, '0);
    send_word(ACT_CHOOSE, 32'd0, 8'd0, '0, '0, '0);
    write_policy(1'b1);
    send_word(ACT_REGISTER, 32'd0, 8'd255, '0, '0, '0);
    send_word(ACT_REGISTER, 32'd0, 8'd7, '0, '0, '0);
    send_word(ACT_REGISTER, 32'd0, 8'd7, '0, '0, '0);
    send_word(ACT_CHOOSE, 32'd0, 8'd0, '0, '0, '0);
    send_word(ACT_PROFILE, '0, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(ACT_PROFILE, '0, 8'd7, 32'd1, 32'hFFFF_FFFF, 16'd0);
    send_word(ACT_PROFILE, '0, 8'd0, 32'd3, 32'd3000, 16'd0);
    send_word(ACT_CHOOSE, 32'd0, 8'd0, '0, '0, '0);
    send_word(ACT_CHOOSE, 32'hFFFF_FFFF, 8'd0, '0, '0, '0);
    send_word(ACT_NONE, 32'hFFFF_FFFF, 8'hFF, '1, '1, '1);
    send_word(ACT_REGISTER, 32'hFFFF_FFFF, 8'd1, '1, '1, '1);
    send_word(ACT_CHOOSE, 32'hFFFF_FFFF, 8'hFF, '1, '1, '1);

    // Fill one group to capacity, then choose from it.
    for (int i = 0; i < MAX_PER_GROUP; i++)
      send_word(ACT_REGISTER, key_pool[2], i[7:0], '0, '0, '0);
    send_word(ACT_CHOOSE, key_pool[2], '0, '0, '0, '0);

    // Long receiver hold-off while the sender keeps offering.
    long_hold = 1;
    fork
      begin
        repeat (400) @(posedge clk);
        long_hold = 0;
      end
      for (int i = 0; i < 10; i++) send_random();
    join

    // Random traffic, policy toggled between phases.
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3) write_policy(1'b0);
      if (i == N_RANDOM / 2) write_policy(1'b1);
      if (i == N_RANDOM - TAIL_ITEMS) quiet_phase = 1;
      send_random();
    end

    // Exhaust the group table: table full.
    for (int i = 0; i < MAX_GROUPS + 2; i++)
      send_word(ACT_REGISTER, 32'hA000_0000 + i, 8'($urandom()), '0, '0, '0);
    send_word(ACT_CHOOSE, 32'hA000_0010, '0, '0, '0, '0);
    drop_valid();

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_capability_operator_selector: done, clean");
    end else begin
      $display("tb_capability_operator_selector: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
sv/cos_pkg.sv
sv/capability_operator_selector.sv
test/tb_capability_operator_selector.sv
